### rtl/stun_xor_mapped_address_parser_top_assert.svh
// assertion macros for the stun xor-mapped address parser
// expects i_clk and i_rst_n in the scope of every use
`ifndef STUN_XOR_MAPPED_ADDRESS_PARSER_TOP_ASSERT_SVH
`define STUN_XOR_MAPPED_ADDRESS_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, muted while reset is held
`define STUN_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("stun parser assertion failed");

// clocked check that also holds during reset
`define STUN_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("stun parser assertion failed");

`else

`define STUN_ASSERT(lbl, prop)
`define STUN_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

### rtl/stun_pkg.sv
// constants, types and helpers for the stun xor-mapped address parser
// no dependencies
package stun_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 2048;
    localparam int unsigned POS_W            = $clog2(MAX_PACKET_BYTES + 1);

    localparam logic [31:0] STUN_COOKIE   = 32'h2112A442;
    localparam logic [15:0] XOR_ADDR_TYPE = 16'h0020;
    localparam logic [7:0]  FAMILY_IPV4   = 8'h01;
    localparam logic [15:0] HEADER_BYTES  = 16'd20;

    // byte offsets inside one attribute
    localparam logic [3:0] OFF_TYPE_HI  = 4'd0;
    localparam logic [3:0] OFF_TYPE_LO  = 4'd1;
    localparam logic [3:0] OFF_LEN_HI   = 4'd2;
    localparam logic [3:0] OFF_LEN_LO   = 4'd3;
    localparam logic [3:0] OFF_RESERVED = 4'd4;
    localparam logic [3:0] OFF_FAMILY   = 4'd5;
    localparam logic [3:0] OFF_PORT_HI  = 4'd6;
    localparam logic [3:0] OFF_PORT_LO  = 4'd7;
    localparam logic [3:0] OFF_ADDR_0   = 4'd8;
    localparam logic [3:0] OFF_ADDR_1   = 4'd9;
    localparam logic [3:0] OFF_ADDR_2   = 4'd10;
    localparam logic [3:0] OFF_ADDR_3   = 4'd11;
    localparam logic [15:0] ATTR_SPAN   = 16'd12;

    localparam int unsigned OUT_TDATA_W = 56;

    typedef struct packed {
        logic        first_success;
        logic        address_changed;
        logic [15:0] mapped_port;
        logic [31:0] mapped_address;
        logic        mapped_found;
    } t_result;

    // cookie byte expected at packet positions 4 to 7, most significant first
    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = STUN_COOKIE[31:24];
            2'd1:    b = STUN_COOKIE[23:16];
            2'd2:    b = STUN_COOKIE[15:8];
            default: b = STUN_COOKIE[7:0];
        endcase
        return b;
    endfunction

    // start of the following attribute, saturating at 0xffff
    function automatic logic [15:0] next_start(input logic [15:0] start,
                                               input logic [15:0] len);
        logic [16:0] sum;
        sum = {1'b0, start} + 17'd4 + {1'b0, len};
        return sum[16] ? 16'hFFFF : sum[15:0];
    endfunction

endpackage

### rtl/stun_xor_mapped_address_parser_top.sv
// stun xor-mapped address parser, top level
// depends on stun_pkg and stun_xor_mapped_address_parser_top_assert.svh
//
// channel  | dir | beat content
// s_axis   | in  | tdata[7:0] datagram byte, tlast marks the final byte
// m_axis   | out | tdata: found, address[32], port[16], changed, first_success
//
// one byte per cycle unless a tlast beat waits on m_axis: a beat lands in the input
// register, then the parse logic consumes it and updates the packet state
// a result is loaded into the output register on the consume of a tlast beat
// reset clears parse state, public address and both valid flags
// m_axis stall only blocks the input register while it holds a tlast beat
// whose result has nowhere to go; other bytes keep flowing
module stun_xor_mapped_address_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] mapped_found, [32:1] mapped_address, [48:33] mapped_port,
    // [49] address_changed, [50] first_success, [55:51] zero
    output logic [stun_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    `include "stun_xor_mapped_address_parser_top_assert.svh"

    localparam int unsigned PW = stun_pkg::POS_W;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;

    // packet parse state
    logic [PW-1:0] r_pos,    n_pos;
    logic [15:0]   r_start,  n_start;
    logic          r_cookie, n_cookie;
    logic [15:0]   r_type,   n_type;
    logic [15:0]   r_len,    n_len;
    logic [7:0]    r_family, n_family;
    logic [15:0]   r_cport,  n_cport;
    logic [31:0]   r_caddr,  n_caddr;
    logic          r_done,   n_done;
    logic [7:0]    r_held,   n_held;

    // discovery state kept across packets
    logic [31:0] r_pub_addr, n_pub_addr;
    logic [15:0] r_pub_port, n_pub_port;
    logic        r_init_done, n_init_done;

    // output register
    logic               r_out_valid;
    stun_pkg::t_result  r_out, n_out;

    logic        consume;
    logic        load;
    logic [15:0] pos16;
    logic [15:0] off;
    logic        in_attr;
    logic [15:0] len_full;
    logic [31:0] dec_addr;
    logic [15:0] dec_port;
    logic        found;
    logic        changed;

    // input register drains unless it holds a tlast beat and the result slot is stuck
    assign consume       = r_in_valid && !(r_in_last && r_out_valid && !m_axis_tready);
    assign load          = consume && r_in_last;
    assign s_axis_tready = !r_in_valid || consume;

    assign pos16    = 16'(r_pos);
    assign off      = pos16 - r_start;
    assign in_attr  = !r_done && (pos16 >= r_start) && (off < stun_pkg::ATTR_SPAN);
    assign len_full = {r_len[15:8], r_len[7:0] | r_in_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // byte parse
    always_comb begin
        n_pos    = r_pos;
        n_start  = r_start;
        n_cookie = r_cookie;
        n_type   = r_type;
        n_len    = r_len;
        n_family = r_family;
        n_cport  = r_cport;
        n_caddr  = r_caddr;
        n_done   = r_done;
        n_held   = r_held;
        if (consume && (r_pos < PW'(stun_pkg::MAX_PACKET_BYTES))) begin
            n_pos = r_pos + PW'(1);
            // cookie window is positions 4 to 7
            if ((r_pos[PW-1:2] == (PW-2)'(1)) &&
                (r_in_data != stun_pkg::cookie_byte(r_pos[1:0]))) begin
                n_cookie = 1'b0;
            end
            if (in_attr) begin
                case (off[3:0])
                    stun_pkg::OFF_TYPE_HI: begin
                        n_type = {r_in_data, 8'h00};
                    end
                    stun_pkg::OFF_TYPE_LO: begin
                        n_type = {r_type[15:8], r_type[7:0] | r_in_data};
                    end
                    stun_pkg::OFF_LEN_HI: begin
                        n_len = {r_in_data, 8'h00};
                    end
                    stun_pkg::OFF_LEN_LO: begin
                        n_len = len_full;
                        if (r_type != stun_pkg::XOR_ADDR_TYPE) begin
                            n_start = stun_pkg::next_start(r_start, len_full);
                        end
                    end
                    stun_pkg::OFF_RESERVED: begin
                        n_held = r_in_data;
                    end
                    stun_pkg::OFF_FAMILY: begin
                        n_family = r_in_data;
                        if (r_in_data != stun_pkg::FAMILY_IPV4) begin
                            // short non-ipv4 attribute: next header overlaps bytes seen
                            if (r_len == 16'd0) begin
                                n_type = {r_held, r_in_data};
                            end else if (r_len == 16'd1) begin
                                n_type = {r_in_data, 8'h00};
                            end
                            n_start = stun_pkg::next_start(r_start, r_len);
                        end
                    end
                    stun_pkg::OFF_PORT_HI: begin
                        n_cport = {r_in_data, 8'h00};
                    end
                    stun_pkg::OFF_PORT_LO: begin
                        n_cport = {r_cport[15:8], r_cport[7:0] | r_in_data};
                    end
                    stun_pkg::OFF_ADDR_0,
                    stun_pkg::OFF_ADDR_1,
                    stun_pkg::OFF_ADDR_2: begin
                        n_caddr = {r_caddr[23:0], r_in_data};
                    end
                    stun_pkg::OFF_ADDR_3: begin
                        n_caddr = {r_caddr[23:0], r_in_data};
                        n_done  = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result of the packet, seen through the byte just parsed
    assign found    = n_cookie && n_done;
    assign dec_addr = n_caddr ^ stun_pkg::STUN_COOKIE;
    assign dec_port = n_cport ^ stun_pkg::STUN_COOKIE[31:16];
    assign changed  = found && ((dec_addr != r_pub_addr) || (dec_port != r_pub_port));

    always_comb begin
        n_out.mapped_found    = found;
        n_out.mapped_address  = found ? dec_addr : 32'd0;
        n_out.mapped_port     = found ? dec_port : 16'd0;
        n_out.address_changed = changed;
        n_out.first_success   = changed && !r_init_done;
        n_pub_addr            = r_pub_addr;
        n_pub_port            = r_pub_port;
        n_init_done           = r_init_done;
        if (load && changed) begin
            n_pub_addr  = dec_addr;
            n_pub_port  = dec_port;
            n_init_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || load) begin
            // end of packet returns the parse state to its start
            r_pos    <= '0;
            r_start  <= stun_pkg::HEADER_BYTES;
            r_cookie <= 1'b1;
            r_type   <= '0;
            r_len    <= '0;
            r_family <= '0;
            r_cport  <= '0;
            r_caddr  <= '0;
            r_done   <= 1'b0;
            r_held   <= '0;
        end else begin
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_cookie <= n_cookie;
            r_type   <= n_type;
            r_len    <= n_len;
            r_family <= n_family;
            r_cport  <= n_cport;
            r_caddr  <= n_caddr;
            r_done   <= n_done;
            r_held   <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pub_addr  <= '0;
            r_pub_port  <= '0;
            r_init_done <= 1'b0;
        end else begin
            r_pub_addr  <= n_pub_addr;
            r_pub_port  <= n_pub_port;
            r_init_done <= n_init_done;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(stun_pkg::OUT_TDATA_W - $bits(stun_pkg::t_result))'(0), r_out};

    // first success only comes with a change
    `STUN_ASSERT(a_first_needs_change,
        r_out_valid |-> (!r_out.first_success || r_out.address_changed))
    // no address or port leaks out of a not-found result
    `STUN_ASSERT(a_zero_when_missing,
        (r_out_valid && !r_out.mapped_found) |->
            (r_out.mapped_address == 32'd0 && r_out.mapped_port == 16'd0))
    // a changed result leaves discovery done and the public address updated
    `STUN_ASSERT(a_public_updates,
        (load && changed) |=> (r_init_done && r_pub_addr == r_out.mapped_address
            && r_pub_port == r_out.mapped_port))

endmodule

### bench/tb_top.sv
// self-checking bench for the stun xor-mapped address parser: byte stream in, one
// decoded mapping per datagram out, predicted here and compared field by field
// depends on stun_pkg and stun_xor_mapped_address_parser_top
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stun_pkg::*;

    localparam int RES_W = $bits(t_result);

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic                   s_axis_tlast  = 1'b0;    // last_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [0] found, [32:1] address, [48:33] port, [49] changed, [50] first_success
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    stun_xor_mapped_address_parser_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow of the parser: packet walk state plus the remembered public
    // endpoint, advanced on every accepted input beat
    // ------------------------------------------------------------------
    logic [15:0] walk_pos;
    logic [15:0] walk_start;      // first byte of the attribute being walked
    logic        cookie_ok;
    logic [15:0] walk_type;
    logic [15:0] walk_len;
    logic [7:0]  walk_family;
    logic [7:0]  held_rsvd;
    logic [15:0] xport;           // still xor-ed with the cookie
    logic [31:0] xaddr;
    logic        have_mapping;    // ipv4 mapping fully captured, stop parsing
    logic [31:0] known_addr;
    logic [15:0] known_port;
    logic        discovered;

    // one decoded mapping per datagram, oldest first
    t_result pending_mappings[$];

    int  fail_count    = 0;
    int  bytes_sent    = 0;
    int  packets_sent  = 0;
    int  results_seen  = 0;
    int  found_count   = 0;
    int  changed_count = 0;
    int  first_count   = 0;
    bit  idle_en       = 1'b1;
    int  stall_left    = 0;

    logic [7:0]  pkt[$];          // datagram under construction
    logic [15:0] prev_port = 16'h0;
    logic [31:0] prev_addr = 32'h0;

    task automatic clear_walk;
        walk_pos     = 16'd0;
        walk_start   = HEADER_BYTES;
        cookie_ok    = 1'b1;
        walk_type    = 16'h0;
        walk_len     = 16'h0;
        walk_family  = 8'h0;
        held_rsvd    = 8'h0;
        xport        = 16'h0;
        xaddr        = 32'h0;
        have_mapping = 1'b0;
    endtask

    // jump to the next attribute, saturating at 0xffff
    task automatic skip_attr;
        logic [16:0] nxt;
        nxt = {1'b0, walk_start} + 17'd4 + {1'b0, walk_len};
        walk_start = nxt[16] ? 16'hFFFF : nxt[15:0];
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [15:0] p;
        logic [15:0] off;
        t_result     r;
        if (walk_pos < MAX_PACKET_BYTES) begin
            p = walk_pos;
            walk_pos = walk_pos + 16'd1;
            if (p >= 16'd4 && p <= 16'd7 && b != STUN_COOKIE[8 * (7 - int'(p)) +: 8])
                cookie_ok = 1'b0;
            if (!have_mapping && p >= walk_start) begin
                off = p - walk_start;
                case (off)
                    OFF_TYPE_HI: walk_type = {b, 8'h00};
                    OFF_TYPE_LO: walk_type = walk_type | {8'h00, b};
                    OFF_LEN_HI:  walk_len = {b, 8'h00};
                    OFF_LEN_LO: begin
                        walk_len = walk_len | {8'h00, b};
                        if (walk_type != XOR_ADDR_TYPE)
                            skip_attr();
                    end
                    OFF_RESERVED: held_rsvd = b;
                    OFF_FAMILY: begin
                        walk_family = b;
                        if (b != FAMILY_IPV4) begin
                            // short value: the next type overlaps bytes already seen
                            if (walk_len == 16'd0)
                                walk_type = {held_rsvd, b};
                            else if (walk_len == 16'd1)
                                walk_type = {b, 8'h00};
                            skip_attr();
                        end
                    end
                    OFF_PORT_HI: xport = {b, 8'h00};
                    OFF_PORT_LO: xport = xport | {8'h00, b};
                    OFF_ADDR_0, OFF_ADDR_1, OFF_ADDR_2, OFF_ADDR_3: begin
                        xaddr = {xaddr[23:0], b};
                        if (off == OFF_ADDR_3)
                            have_mapping = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        if (last) begin
            r = '0;
            if (cookie_ok && have_mapping) begin
                r.mapped_found   = 1'b1;
                r.mapped_address = xaddr ^ STUN_COOKIE;
                r.mapped_port    = xport ^ STUN_COOKIE[31:16];
                if (r.mapped_address != known_addr || r.mapped_port != known_port) begin
                    r.address_changed = 1'b1;
                    r.first_success   = !discovered;
                    known_addr = r.mapped_address;
                    known_port = r.mapped_port;
                    discovered = 1'b1;
                end
            end
            pending_mappings.push_back(r);
            clear_walk();
        end
    endtask

    // ------------------------------------------------------------------
    // input side: one beat per call, random idle bursts ahead of it
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        decode_byte(b, last);
    endtask

    task automatic send_packet;
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
        pkt.delete();
        packets_sent++;
    endtask

    // datagram building blocks, multi-byte fields big endian
    function automatic void put16(input logic [15:0] v);
        pkt.push_back(v[15:8]);
        pkt.push_back(v[7:0]);
    endfunction

    function automatic void put32(input logic [31:0] v);
        put16(v[31:16]);
        put16(v[15:0]);
    endfunction

    // binding response header with a random transaction id
    function automatic void put_header(input logic [31:0] cookie);
        put16(16'h0101);
        put16(16'($urandom));
        put32(cookie);
        repeat (3) put32($urandom);
    endfunction

    function automatic void put_attr(input logic [15:0] atype, input logic [15:0] alen);
        put16(atype);
        put16(alen);
        repeat (alen) pkt.push_back(8'($urandom));
    endfunction

    // port and address as they travel, xor-ed with the cookie
    function automatic void put_endpoint(input logic [15:0] port, input logic [31:0] addr);
        put16(port ^ STUN_COOKIE[31:16]);
        put32(addr ^ STUN_COOKIE);
    endfunction

    function automatic void put_mapping(input logic [15:0] alen, input logic [15:0] port,
                                        input logic [31:0] addr);
        put16(XOR_ADDR_TYPE);
        put16(alen);
        pkt.push_back(8'($urandom));
        pkt.push_back(FAMILY_IPV4);
        put_endpoint(port, addr);
    endfunction

    // xor-mapped attribute of some other family, value filled to its length, at least two bytes
    function automatic void put_foreign_mapping(input logic [15:0] alen, input logic [7:0] fam);
        put16(XOR_ADDR_TYPE);
        put16(alen);
        pkt.push_back(8'($urandom));
        pkt.push_back(fam);
        repeat ((alen > 16'd2) ? alen - 16'd2 : 0) pkt.push_back(8'($urandom));
    endfunction

    // mostly well-formed responses with random content, some noise
    task automatic random_packet;
        int          k;
        int          cut;
        logic [15:0] alen;
        logic [15:0] atype;
        logic [7:0]  fam;
        logic [31:0] cookie;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 48)) pkt.push_back(8'($urandom));
        end else begin
            cookie = STUN_COOKIE;
            if ($urandom_range(0, 9) == 0) begin
                k = $urandom_range(0, 3);
                cookie[8 * k +: 8] = cookie[8 * k +: 8] ^ 8'($urandom_range(1, 255));
            end
            put_header(cookie);
            repeat ($urandom_range(0, 3)) begin
                alen = 16'($urandom_range(0, 8));
                if ($urandom_range(0, 3) == 0) begin
                    fam = 8'($urandom);
                    if (fam == FAMILY_IPV4)
                        fam = 8'h02;
                    put_foreign_mapping(alen, fam);
                end else begin
                    atype = 16'($urandom);
                    if (atype == XOR_ADDR_TYPE)
                        atype = ~atype;
                    put_attr(atype, alen);
                end
            end
            if ($urandom_range(0, 6) != 0) begin
                // reuse the last endpoint now and then so unchanged results show up
                if ($urandom_range(0, 2) != 0) begin
                    prev_port = 16'($urandom);
                    prev_addr = $urandom;
                end
                put_mapping(($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 20)) : 16'd8,
                            prev_port, prev_addr);
            end
            repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom));
            if ($urandom_range(0, 6) == 0) begin
                cut = $urandom_range(1, pkt.size());
                while (pkt.size() > cut)
                    void'(pkt.pop_back());
            end
        end
        send_packet();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_discovery;
        // decodes to the reset public endpoint: found, nothing changes
        put_header(STUN_COOKIE);
        put_mapping(16'd8, 16'h0000, 32'h0000_0000);
        send_packet();
        // all-ones endpoint completes discovery
        put_header(STUN_COOKIE);
        put_mapping(16'd8, 16'hFFFF, 32'hFFFF_FFFF);
        send_packet();
        // same endpoint again: found but unchanged
        put_header(STUN_COOKIE);
        put_mapping(16'd8, 16'hFFFF, 32'hFFFF_FFFF);
        send_packet();
        // endpoint moves; the second mapping after the match must be ignored
        put_header(STUN_COOKIE);
        put_mapping(16'd8, 16'd3478, 32'hC0A8_0001);
        put_mapping(16'd8, 16'd1, 32'h0A00_0001);
        send_packet();
        // the ipv4 length field is not checked
        put_header(STUN_COOKIE);
        put_mapping(16'd0, 16'h8000, 32'h8000_0000);
        send_packet();
    endtask

    task automatic test_cookie;
        logic [31:0] cookie;
        // each cookie byte wrong in turn
        for (int i = 0; i < 4; i++) begin
            cookie = STUN_COOKIE;
            cookie[8 * i +: 8] = ~cookie[8 * i +: 8];
            put_header(cookie);
            put_mapping(16'd8, 16'd5000, 32'h0102_0304);
            send_packet();
        end
        // too short to hold the cookie
        pkt.push_back(8'h01);
        send_packet();
        put16(16'h0101);
        put16(16'h0000);
        pkt.push_back(STUN_COOKIE[31:24]);
        pkt.push_back(STUN_COOKIE[23:16]);
        send_packet();
        // header only
        put_header(STUN_COOKIE);
        send_packet();
    endtask

    task automatic test_attribute_walk;
        // unrelated attribute ahead of the mapping
        put_header(STUN_COOKIE);
        put_attr(16'h8022, 16'd5);
        put_mapping(16'd8, 16'd1234, 32'h0B0C_0D0E);
        send_packet();
        // ipv6 mapping skipped by its length
        put_header(STUN_COOKIE);
        put_foreign_mapping(16'd20, 8'h02);
        put_mapping(16'd8, 16'd2222, 32'h5F00_0001);
        send_packet();
        // foreign family, length 0: reserved and family bytes form the next type
        put_header(STUN_COOKIE);
        put16(XOR_ADDR_TYPE);
        put16(16'd0);
        pkt.push_back(XOR_ADDR_TYPE[15:8]);
        pkt.push_back(XOR_ADDR_TYPE[7:0]);
        put16(16'd8);
        pkt.push_back(8'h00);
        pkt.push_back(FAMILY_IPV4);
        put_endpoint(16'd4000, 32'h2233_4455);
        send_packet();
        // foreign family, length 1: family byte is the high half of the next type
        put_header(STUN_COOKIE);
        put16(XOR_ADDR_TYPE);
        put16(16'd1);
        pkt.push_back(8'h5A);
        pkt.push_back(XOR_ADDR_TYPE[15:8]);
        pkt.push_back(XOR_ADDR_TYPE[7:0]);
        put16(16'd8);
        pkt.push_back(8'h00);
        pkt.push_back(FAMILY_IPV4);
        put_endpoint(16'd4001, 32'h6677_8899);
        send_packet();
        // cut inside the address
        put_header(STUN_COOKIE);
        put_mapping(16'd8, 16'd7000, 32'hAABB_CCDD);
        void'(pkt.pop_back());
        void'(pkt.pop_back());
        send_packet();
        // cut inside an attribute header
        put_header(STUN_COOKIE);
        put16(XOR_ADDR_TYPE);
        send_packet();
        // length runs past 0xffff, the walk saturates and never resumes
        put_header(STUN_COOKIE);
        put16(16'h8001);
        put16(16'hFFFF);
        put_mapping(16'd8, 16'd9000, 32'h0102_0304);
        send_packet();
    endtask

    task automatic test_random_traffic(input int budget);
        int stop_at;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at)
            random_packet();
    endtask

    // back to back on both sides
    task automatic test_steady_stream;
        idle_en = 1'b0;
        test_random_traffic(300);
    endtask

    // ------------------------------------------------------------------
    // output side: random stall bursts on tready
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!idle_en) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare every result beat with the oldest predicted mapping
    always @(posedge i_clk) begin : check_result
        t_result          got;
        t_result          want;
        logic [OUT_TDATA_W-RES_W-1:0] pad;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[RES_W-1:0];
            pad = m_axis_tdata[OUT_TDATA_W-1:RES_W];
            results_seen++;
            if (pending_mappings.size() == 0) begin
                if (fail_count < 10)
                    $display("result beat %0d with no datagram pending: %h",
                             results_seen, m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_mappings.pop_front();
                if (got.mapped_found !== want.mapped_found ||
                    got.mapped_address !== want.mapped_address ||
                    got.mapped_port !== want.mapped_port ||
                    got.address_changed !== want.address_changed ||
                    got.first_success !== want.first_success ||
                    pad !== '0) begin
                    if (fail_count < 10)
                        $display({"mismatch on result %0d (exp/got): found %0b/%0b ",
                                  "addr %08h/%08h port %04h/%04h changed %0b/%0b ",
                                  "first %0b/%0b pad %0h"},
                                 results_seen, want.mapped_found, got.mapped_found,
                                 want.mapped_address, got.mapped_address,
                                 want.mapped_port, got.mapped_port,
                                 want.address_changed, got.address_changed,
                                 want.first_success, got.first_success, pad);
                    fail_count++;
                end
                found_count   += got.mapped_found;
                changed_count += got.address_changed;
                first_count   += got.first_success;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        clear_walk();
        known_addr = 32'h0;
        known_port = 16'h0;
        discovered = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_discovery();
        test_cookie();
        test_attribute_walk();
        test_random_traffic(820);
        test_steady_stream();

        s_axis_tvalid <= 1'b0;
        while (pending_mappings.size() != 0)
            @(posedge i_clk);
        // input register, parse stage and output register, plus margin
        repeat (20) @(posedge i_clk);

        if (pending_mappings.size() != 0) begin
            $display("%0d predicted results never arrived", pending_mappings.size());
            fail_count++;
        end

        $display("sent %0d datagrams in %0d bytes, checked %0d results", packets_sent,
                 bytes_sent, results_seen);
        $display("mappings found %0d, endpoint changes %0d, first discoveries %0d",
                 found_count, changed_count, first_count);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("timeout with %0d results outstanding", pending_mappings.size());
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
